// ----- hdl/lkdrq_pkg.sv -----
// ----------------------------------------------------------------------------
// LOOK disk request queue package
// Transaction types, command codes and status codes shared by the queue RTL.
// ----------------------------------------------------------------------------
package lkdrq_pkg;

    localparam int TAG_W    = 16;
    localparam int TRACK_W  = 10;
    localparam int STATUS_W = 2;

    typedef enum logic {
        CMD_ADD = 1'b0,
        CMD_GET = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [0:0]         command;
        logic [TAG_W-1:0]   request_tag;
        logic [TRACK_W-1:0] request_track;
        logic [TRACK_W-1:0] head_track;
    } in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TAG_W-1:0]    out_tag;
        logic [TRACK_W-1:0]  out_track;
        logic [0:0]          now_empty;
    } out_t;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [TRACK_W-1:0] track;
    } entry_t;

endpackage

// ----- hdl/look_disk_request_queue_unit.sv -----
// ----------------------------------------------------------------------------
// LOOK disk request queue
// Two sorted request tables in one memory, walked by a small sequencer.
// ----------------------------------------------------------------------------
// A get transaction passes through acceptance, one memory read and the load of
// the result register before its output step. An add transaction goes straight
// to the output step when its table is empty or full; otherwise it moves each
// stored entry that must make room up by one place, at most DEPTH - 1 of them,
// then writes the new entry; the single memory port pair moves one entry per
// cycle. The output step repeats while the output register still holds an
// unaccepted result. Each table is a ring in its half of the memory, so a get
// never moves entries. A finished result waits in the output register while the
// next transaction is accepted.
module look_disk_request_queue_unit
    import lkdrq_pkg::*;
#(
    parameter int DEPTH     = 32,
    parameter int MAX_TRACK = 1023
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ADR_W = IDX_W + 1;
    localparam int MEM_DEPTH = 2 * (2 ** IDX_W);
    localparam logic [16:0] MaxTrk = 17'(MAX_TRACK);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_GET,
        S_OUT
    } state_t;

    entry_t mem [0:MEM_DEPTH-1];
    entry_t rd_data_reg;

    state_t            state_reg, state_next;
    logic              sel_reg, sel_next;
    entry_t            entry_reg, entry_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    out_t              res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    out_t              m_data_reg, m_data_next;
    logic [CNT_W-1:0]  near_cnt_reg, near_cnt_next;
    logic [CNT_W-1:0]  far_cnt_reg, far_cnt_next;
    logic [IDX_W-1:0]  near_front_reg, near_front_next;
    logic [IDX_W-1:0]  far_front_reg, far_front_next;

    logic              wr_en;
    logic [ADR_W-1:0]  wr_addr;
    entry_t            wr_data;
    logic [ADR_W-1:0]  rd_addr;

    logic [TRACK_W-1:0] trk_c;
    logic [TRACK_W-1:0] head_c;
    logic               in_far;
    logic [CNT_W-1:0]   in_cnt;
    logic [IDX_W-1:0]   in_front;
    logic [IDX_W-1:0]   sel_front;
    logic               goes_before;

    function automatic logic [IDX_W-1:0] ring_idx(input logic [IDX_W-1:0] front,
                                                  input logic [IDX_W-1:0] offset);
        logic [IDX_W:0] sum;
        sum = {1'b0, front} + {1'b0, offset};
        if (sum >= (IDX_W+1)'(DEPTH)) begin
            sum = sum - (IDX_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign trk_c  = ({7'd0, s_data.request_track} > MaxTrk) ? MaxTrk[TRACK_W-1:0]
                                                             : s_data.request_track;
    assign head_c = ({7'd0, s_data.head_track} > MaxTrk) ? MaxTrk[TRACK_W-1:0]
                                                         : s_data.head_track;
    assign in_far   = (trk_c < head_c);
    assign in_cnt   = in_far ? far_cnt_reg : near_cnt_reg;
    assign in_front = in_far ? far_front_reg : near_front_reg;

    assign sel_front = sel_reg ? far_front_reg : near_front_reg;
    assign goes_before = sel_reg ? (rd_data_reg.track < entry_reg.track)
                                 : (rd_data_reg.track > entry_reg.track);

    always_comb begin
        state_next      = state_reg;
        sel_next        = sel_reg;
        entry_next      = entry_reg;
        pos_next        = pos_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        near_cnt_next   = near_cnt_reg;
        far_cnt_next    = far_cnt_reg;
        near_front_next = near_front_reg;
        far_front_next  = far_front_reg;
        wr_en           = 1'b0;
        wr_addr         = {sel_reg, ring_idx(sel_front, pos_reg)};
        wr_data         = entry_reg;
        rd_addr         = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    res_next = '{status: ST_OK, out_tag: '0, out_track: '0, now_empty: 1'b0};
                    if (s_data.command == CMD_ADD) begin
                        entry_next = '{tag: s_data.request_tag, track: trk_c};
                        sel_next   = in_far;
                        pos_next   = in_cnt[IDX_W-1:0];
                        if (in_cnt == CNT_W'(DEPTH)) begin
                            res_next.status = ST_FULL;
                            state_next      = S_OUT;
                        end else if (in_cnt == '0) begin
                            wr_en   = 1'b1;
                            wr_addr = {in_far, in_front};
                            wr_data = '{tag: s_data.request_tag, track: trk_c};
                            if (in_far) begin
                                far_cnt_next = far_cnt_reg + 1'b1;
                            end else begin
                                near_cnt_next = near_cnt_reg + 1'b1;
                            end
                            state_next = S_OUT;
                        end else begin
                            rd_addr    = {in_far, ring_idx(in_front, IDX_W'(in_cnt - 1'b1))};
                            state_next = S_SHIFT;
                        end
                    end else begin
                        if (near_cnt_reg != '0) begin
                            sel_next   = 1'b0;
                            rd_addr    = {1'b0, near_front_reg};
                            state_next = S_GET;
                        end else if (far_cnt_reg != '0) begin
                            sel_next   = 1'b1;
                            rd_addr    = {1'b1, far_front_reg};
                            state_next = S_GET;
                        end else begin
                            res_next.status = ST_EMPTY;
                            state_next      = S_OUT;
                        end
                    end
                end
            end
            S_SHIFT: begin
                wr_en = 1'b1;
                if ((pos_reg == '0) || !goes_before) begin
                    wr_data = entry_reg;
                    if (sel_reg) begin
                        far_cnt_next = far_cnt_reg + 1'b1;
                    end else begin
                        near_cnt_next = near_cnt_reg + 1'b1;
                    end
                    state_next = S_OUT;
                end else begin
                    wr_data  = rd_data_reg;
                    pos_next = pos_reg - 1'b1;
                    rd_addr  = {sel_reg, ring_idx(sel_front, IDX_W'(pos_reg - IDX_W'(2)))};
                end
            end
            S_GET: begin
                res_next.out_tag   = rd_data_reg.tag;
                res_next.out_track = rd_data_reg.track;
                if (sel_reg) begin
                    far_cnt_next   = far_cnt_reg - 1'b1;
                    far_front_next = ring_idx(far_front_reg, IDX_W'(1));
                end else begin
                    near_cnt_next   = near_cnt_reg - 1'b1;
                    near_front_next = ring_idx(near_front_reg, IDX_W'(1));
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next           = res_reg;
                    m_data_next.now_empty = (near_cnt_reg == '0) && (far_cnt_reg == '0);
                    m_valid_next          = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            near_cnt_reg   <= '0;
            far_cnt_reg    <= '0;
            near_front_reg <= '0;
            far_front_reg  <= '0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            near_cnt_reg   <= near_cnt_next;
            far_cnt_reg    <= far_cnt_next;
            near_front_reg <= near_front_next;
            far_front_reg  <= far_front_next;
        end
        sel_reg    <= sel_next;
        entry_reg  <= entry_next;
        pos_reg    <= pos_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

endmodule
